// File: rtl/cgd_pkg.sv
// Shared types, constants and command/status bundles for the CTC greedy decoder.
`timescale 1ns / 1ps
`default_nettype none

package cgd_pkg;

  // Field widths
  localparam int unsigned ScoreW  = 16;
  localparam int unsigned ClassW  = 15;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SumW    = 25;
  localparam int unsigned EmitW   = 9;
  localparam int unsigned OutDataW = 40;

  // Q1.15 one, and the cap on counted emissions
  localparam logic [ScoreW-1:0] ScoreOne = 16'd32768;
  localparam logic [EmitW-1:0]  EmitCap  = 9'd511;

  // Largest supported class count; the effective count is clamped to this
  localparam int unsigned MaxClasses = 32768;
  localparam int unsigned ClassCapInt = (MaxClasses < 32768) ? MaxClasses : 32768;
  localparam logic [CountW-1:0] ClassCap = CountW'(ClassCapInt);

  // Register reset values
  localparam logic [CountW-1:0] ClassCountReset = 16'd97;
  localparam logic [CountW-1:0] LabelCountReset = 16'd96;

  // Restoring divider: one quotient bit per cycle over the whole sum
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CLASS_COUNT = 1'b0,
    CFG_LABEL_COUNT = 1'b1
  } cgd_cfg_e;

  // Result kinds
  typedef enum logic [0:0] {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } cgd_kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_SUM
  } cgd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic load_char;  // load a character result into the output register
    logic div_start;  // sequence ended: latch sum and count, start divide
    logic div_step;   // run one divider iteration
    logic load_sum;   // load the summary result into the output register
  } cgd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;       // current item closes a step with a new character
    logic div_done;   // divider finished
  } cgd_sts_t;

endpackage

`default_nettype wire

// File: rtl/cgd_ctrl.sv
// Controller: input/output handshakes and sequencing of the end-of-sequence divide.
`timescale 1ns / 1ps
`default_nettype none

module cgd_ctrl
  import cgd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire cgd_sts_t sts_i,
  output cgd_cmd_t      cmd_o
);

  cgd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output register can take a new item this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_RUN) && out_free;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_valid_i && in_ready_o && in_last_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = in_valid_i && in_ready_o;
    cmd_o.load_char = cmd_o.accept && sts_i.emit;
    cmd_o.div_start = cmd_o.accept && in_last_i;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.load_sum  = (state_q == ST_SUM) && out_free;
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_char || cmd_o.load_sum) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cgd_datapath.sv
// Datapath: config registers, per-step argmax, emission, score sum, divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module cgd_datapath
  import cgd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [CountW-1:0]   cfg_data_i,
  input  wire logic [ScoreW-1:0]   class_score_i,
  input  wire logic                sequence_end_i,
  input  wire cgd_cmd_t            cmd_i,
  output cgd_sts_t                 sts_o,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_kind_o,
  output logic                     out_last_o
);

  // Configuration registers
  logic [CountW-1:0] class_count_q, label_count_q;

  // Sequence state
  logic [ClassW-1:0] class_counter_q, class_counter_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [ClassW-1:0] best_class_q, best_class_d;
  logic [ClassW-1:0] prev_class_q, prev_class_d;
  logic [SumW-1:0]   score_sum_q, score_sum_d;
  logic [EmitW-1:0]  emit_count_q, emit_count_d;

  // Divider state
  logic [SumW-1:0]    div_quo_q, div_quo_d;
  logic [EmitW-1:0]   div_rem_q, div_rem_d;
  logic [EmitW-1:0]   div_den_q, div_den_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               sum_empty_q, sum_empty_d;

  // Output payload
  logic [ClassW-1:0] out_idx_q, out_idx_d;
  logic              out_inval_q, out_inval_d;
  logic [ScoreW-1:0] out_mean_q, out_mean_d;
  logic              out_empty_q, out_empty_d;
  logic              out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;

  // Per-item combinational signals
  logic [ScoreW-1:0] score_sat;
  logic [CountW-1:0] n_eff;
  logic              take;
  logic [ScoreW-1:0] cur_score;
  logic [ClassW-1:0] cur_class;
  logic              step_end;
  logic              emit;
  logic              count_it;
  logic [ClassW-1:0] emit_idx;
  logic              emit_inval;
  logic [SumW-1:0]   sum_next;
  logic [EmitW-1:0]  count_next;

  // Divider step signals
  logic [EmitW:0]    div_trial;
  logic              div_fits;
  logic [ScoreW-1:0] mean_clamped;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= ClassCountReset;
      label_count_q <= LabelCountReset;
    end else if (cfg_we_i) begin
      case (cgd_cfg_e'(cfg_index_i))
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i;
        CFG_LABEL_COUNT: label_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate score, clamp class count
  always_comb begin
    score_sat = (class_score_i > ScoreOne) ? ScoreOne : class_score_i;
    n_eff     = (class_count_q == '0) ? CountW'(1) : class_count_q;
    if (n_eff > ClassCap) n_eff = ClassCap;
  end

  // Running argmax and step close
  always_comb begin
    take       = (class_counter_q == '0) || (score_sat > best_score_q);
    cur_score  = take ? score_sat : best_score_q;
    cur_class  = take ? class_counter_q : best_class_q;
    step_end   = (({1'b0, class_counter_q} + CountW'(1)) >= n_eff) || sequence_end_i;
    emit       = step_end && (cur_class != '0) && (cur_class != prev_class_q);
    emit_idx   = cur_class - ClassW'(1);
    emit_inval = ({1'b0, emit_idx} >= label_count_q);
    count_it   = emit && (emit_count_q != EmitCap);
    sum_next   = count_it ? (score_sum_q + {{(SumW-ScoreW){1'b0}}, cur_score}) : score_sum_q;
    count_next = count_it ? (emit_count_q + EmitW'(1)) : emit_count_q;
  end

  // Sequence state update
  always_comb begin
    class_counter_d = class_counter_q;
    best_score_d    = best_score_q;
    best_class_d    = best_class_q;
    prev_class_d    = prev_class_q;
    score_sum_d     = score_sum_q;
    emit_count_d    = emit_count_q;
    if (cmd_i.accept) begin
      if (step_end) begin
        prev_class_d    = cur_class;
        class_counter_d = '0;
        best_score_d    = '0;
        best_class_d    = '0;
      end else begin
        class_counter_d = class_counter_q + ClassW'(1);
        best_score_d    = cur_score;
        best_class_d    = cur_class;
      end
      score_sum_d  = sum_next;
      emit_count_d = count_next;
      // sequence boundary: back to reset
      if (sequence_end_i) begin
        class_counter_d = '0;
        best_score_d    = '0;
        best_class_d    = '0;
        prev_class_d    = '0;
        score_sum_d     = '0;
        emit_count_d    = '0;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; remainder stays below a nonzero divisor
  always_comb begin
    div_trial   = {div_rem_q, div_quo_q[SumW-1]};
    div_fits    = (div_trial >= {1'b0, div_den_q});
    div_quo_d   = div_quo_q;
    div_rem_d   = div_rem_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    sum_empty_d = sum_empty_q;
    if (cmd_i.div_start) begin
      div_quo_d   = sum_next;
      div_rem_d   = '0;
      div_den_d   = count_next;
      div_cnt_d   = DivCntW'(DivSteps);
      sum_empty_d = (count_next == '0);
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_rem_d = div_fits ? EmitW'(div_trial - {1'b0, div_den_q}) : div_trial[EmitW-1:0];
      div_quo_d = {div_quo_q[SumW-2:0], div_fits};
      div_cnt_d = div_cnt_q - DivCntW'(1);
    end
  end

  always_comb begin
    mean_clamped = (div_quo_q > {{(SumW-ScoreW){1'b0}}, ScoreOne}) ?
                   ScoreOne : div_quo_q[ScoreW-1:0];
  end

  // Output register load
  always_comb begin
    out_idx_d   = out_idx_q;
    out_inval_d = out_inval_q;
    out_mean_d  = out_mean_q;
    out_empty_d = out_empty_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (cmd_i.load_char) begin
      out_idx_d   = emit_idx;
      out_inval_d = emit_inval;
      out_mean_d  = '0;
      out_empty_d = 1'b0;
      out_kind_d  = KIND_CHAR;
      out_last_d  = 1'b0;
    end else if (cmd_i.load_sum) begin
      out_idx_d   = '0;
      out_inval_d = 1'b0;
      out_mean_d  = sum_empty_q ? '0 : mean_clamped;
      out_empty_d = sum_empty_q;
      out_kind_d  = KIND_SUMMARY;
      out_last_d  = 1'b1;
    end
  end

  // Control-state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_counter_q <= '0;
      best_score_q    <= '0;
      best_class_q    <= '0;
      prev_class_q    <= '0;
      score_sum_q     <= '0;
      emit_count_q    <= '0;
      div_cnt_q       <= '0;
    end else begin
      class_counter_q <= class_counter_d;
      best_score_q    <= best_score_d;
      best_class_q    <= best_class_d;
      prev_class_q    <= prev_class_d;
      score_sum_q     <= score_sum_d;
      emit_count_q    <= emit_count_d;
      div_cnt_q       <= div_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    div_quo_q   <= div_quo_d;
    div_rem_q   <= div_rem_d;
    div_den_q   <= div_den_d;
    sum_empty_q <= sum_empty_d;
    out_idx_q   <= out_idx_d;
    out_inval_q <= out_inval_d;
    out_mean_q  <= out_mean_d;
    out_empty_q <= out_empty_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  // Status and output packing
  assign sts_o.emit     = emit;
  assign sts_o.div_done = (div_cnt_q == '0);

  assign out_data_o = {{(OutDataW-ClassW-1-ScoreW-1){1'b0}},
                       out_empty_q, out_mean_q, out_inval_q, out_idx_q};
  assign out_kind_o = out_kind_q;
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

// File: rtl/ctc_greedy_decoder_unit.sv
// A character item is registered from the score that closes its step and appears in the
// cycle after its acceptance. For the summary the last score's accept latches sum and
// count, the bit-serial divider runs, the controller sees it done, then the summary is
// loaded when the output is free. Throughput: one score per cycle within a sequence while
// the output drains; after a sequence end input waits for the divide and summary load.
// Reset (rst_ni low, async) clears sequence state, sets class_count 97 and label_count 96.
`timescale 1ns / 1ps
`default_nettype none

module ctc_greedy_decoder_unit
  import cgd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [CountW-1:0]   cfg_data_i,
  // score input
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [ScoreW-1:0]   s_axis_tdata_i,   // [15:0] class_score
  input  wire logic                s_axis_tlast_i,   // sequence_end
  // result output
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,   // [14:0] label_index, [15] index_invalid,
                                                     // [31:16] mean_score, [32] text_empty,
                                                     // [39:33] zero
  output logic                     m_axis_tuser_o,   // item_kind
  output logic                     m_axis_tlast_o    // last
);

  cgd_cmd_t cmd;
  cgd_sts_t sts;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  cgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cgd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .class_score_i  (s_axis_tdata_i),
    .sequence_end_i (s_axis_tlast_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_data_o     (m_axis_tdata_o),
    .out_kind_o     (m_axis_tuser_o),
    .out_last_o     (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the CTC greedy decoder unit: directed table, then random sequences.
`timescale 1ns / 1ps

module tb
  import cgd_pkg::*;
();

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 32;   // margin for the divide and summary load
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned ItemTarget  = 1900;

  // One result item, field by field
  typedef struct packed {
    cgd_kind_e         kind;
    logic [ClassW-1:0] label;
    logic              invalid;
    logic [ScoreW-1:0] mean;
    logic              text_empty;
    logic              is_last;
  } result_t;

  localparam result_t NoResult     = '0;
  localparam result_t EmptySummary = '{KIND_SUMMARY, 15'd0, 1'b0, 16'd0, 1'b1, 1'b1};

  // Directed stimulus row: a score item, or a write of both registers
  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [15:0] a;        // class_score, or class_count for a config row
    logic [15:0] b;        // label_count for a config row
    logic        seq_end;
    int          n_typed;  // -1: results come from the decoder model
    result_t     r0;
    result_t     r1;
  } row_t;

  // DUT ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [0:0]          cfg_index = CFG_CLASS_COUNT;
  logic [CountW-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic [ScoreW-1:0]   s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tready = 1'b0;
  logic                cfg_ready_o;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  ctc_greedy_decoder_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Decoder model state and its copy of the registers
  logic [CountW-1:0] cfg_classes = ClassCountReset;
  logic [CountW-1:0] cfg_labels  = LabelCountReset;
  int unsigned step_pos = 0;
  int unsigned best_score = 0;
  int unsigned best_class = 0;
  int unsigned prior_class = 0;
  int unsigned peak_sum = 0;
  int unsigned emitted = 0;
  bit          cap_hit = 1'b0;

  result_t predicted[$];
  result_t results_due[$];

  // Bookkeeping
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned sequences_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned chars_seen = 0;
  int unsigned summaries_seen = 0;
  int unsigned burst_left = 0;
  int unsigned last_win = 0;
  bit          hold_req = 1'b0;

  row_t directed_rows[28];

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Best-path decode of one score: appends the result items it causes to predicted
  function automatic void greedy_step(input logic [15:0] score_in, input logic seq_end);
    int unsigned n;
    int unsigned score;
    int unsigned winner;
    int unsigned mean;
    result_t     r;
    n = cfg_classes;
    if (n < 1) n = 1;
    if (n > ClassCapInt) n = ClassCapInt;
    score = (score_in > ScoreOne) ? ScoreOne : score_in;
    // first highest score of the step wins
    if (step_pos == 0 || score > best_score) begin
      best_score = score;
      best_class = step_pos;
    end
    // step closes at its last class, or early on a sequence end
    if (step_pos + 1 >= n || seq_end) begin
      winner = best_class;
      if (winner != 0 && winner != prior_class) begin
        r = '0;
        r.kind = KIND_CHAR;
        r.label = ClassW'(winner - 1);
        r.invalid = ((winner - 1) >= cfg_labels);
        predicted.push_back(r);
        if (emitted < EmitCap) begin
          peak_sum += best_score;
          emitted++;
        end else begin
          cap_hit = 1'b1;
        end
      end
      prior_class = winner;
      step_pos = 0;
      best_score = 0;
      best_class = 0;
    end else begin
      step_pos = (step_pos + 1) & 32'h7FFF;
    end
    // summary, then back to reset state
    if (seq_end) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.is_last = 1'b1;
      if (emitted != 0) begin
        mean = peak_sum / emitted;
        if (mean > ScoreOne) mean = ScoreOne;
        r.mean = ScoreW'(mean);
      end else begin
        r.text_empty = 1'b1;
      end
      predicted.push_back(r);
      step_pos = 0;
      best_score = 0;
      best_class = 0;
      prior_class = 0;
      peak_sum = 0;
      emitted = 0;
    end
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("kind=%0d index=%0d invalid=%0b mean=%0d empty=%0b last=%0b",
                     r.kind, r.label, r.invalid, r.mean, r.text_empty, r.is_last);
  endfunction

  // Offer one score item in bursts with random gaps; returns at the accepting edge
  task automatic send_score(input logic [15:0] score, input logic seq_end);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= score;
    s_tlast  <= seq_end;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    if (seq_end) sequences_sent++;
  endtask

  // Send a score and queue what it should produce
  task automatic feed(input logic [15:0] score, input logic seq_end, input int n_typed = -1,
                      input result_t r0 = '0, input result_t r1 = '0);
    send_score(score, seq_end);
    predicted.delete();
    greedy_step(score, seq_end);
    if (n_typed < 0) begin
      foreach (predicted[k]) results_due.push_back(predicted[k]);
    end else begin
      if (n_typed > 0) results_due.push_back(r0);
      if (n_typed > 1) results_due.push_back(r1);
    end
  endtask

  // Stop offering, let every expected item arrive, then allow for divider latency
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write class_count then label_count, valid held high across both
  task automatic configure(input logic [15:0] classes, input logic [15:0] labels);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CLASS_COUNT;
    cfg_data  <= classes;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_classes = classes;
    cfg_index <= CFG_LABEL_COUNT;
    cfg_data  <= labels;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_labels = labels;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // One time step of len scores whose peak sits at class win
  task automatic send_step(input int unsigned len, input int unsigned win,
                           input logic close_seq, input bit noisy);
    logic [15:0] peak;
    logic [15:0] score;
    int unsigned top;
    case ($urandom_range(0, 11))
      0:       peak = ScoreOne;
      1:       peak = 16'hFFFF;
      2:       peak = 16'($urandom_range(32769, 65535));
      default: peak = 16'($urandom_range(1, 32768));
    endcase
    top = (peak > ScoreOne) ? ScoreOne : peak;
    for (int unsigned j = 0; j < len; j++) begin
      // earlier classes stay below the peak, later ones may tie it
      if (j == win) score = peak;
      else if (j < win) score = 16'($urandom_range(0, top - 1));
      else score = 16'($urandom_range(0, top));
      if (noisy && $urandom_range(0, 19) == 0) score = 16'($urandom);
      feed(score, close_seq && (j == len - 1));
    end
  endtask

  // A sequence of a few steps; huge class counts get one partial step
  task automatic run_sequence(input int unsigned n);
    int unsigned steps;
    int unsigned len;
    int unsigned win;
    steps = (n > 48) ? 1 : $urandom_range(1, 6);
    for (int unsigned s = 0; s < steps; s++) begin
      len = (n > 48) ? $urandom_range(1, 24) : n;
      if (s == steps - 1 && len > 1 && $urandom_range(0, 4) == 0)
        len = $urandom_range(1, len - 1);
      case ($urandom_range(0, 9))
        0, 1:    win = 0;
        2, 3:    win = last_win;
        default: win = $urandom_range(0, len - 1);
      endcase
      last_win = win;
      send_step(len, win, s == steps - 1, 1'b1);
    end
  endtask

  // Three classes, winners alternate so nearly every step emits; runs past the emit cap
  task automatic run_long_sequence();
    int unsigned count;
    int unsigned win;
    count = 0;
    win = 1;
    while (count < EmitCap + 12) begin
      if ($urandom_range(0, 19) == 0) begin
        send_step(3, 0, 1'b0, 1'b0);
      end else begin
        win = 3 - win;
        send_step(3, win, 1'b0, 1'b0);
        count++;
      end
    end
    send_step(3, $urandom_range(0, 2), 1'b1, 1'b0);
  endtask

  // Result sink: checks each accepted item, drives tready on its own pattern
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned sink_mode;
    result_t     got;
    result_t     want;
    hold_left = 0;
    sink_mode = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (m_axis_tvalid_o && m_tready) begin
        got.kind       = cgd_kind_e'(m_axis_tuser_o);
        got.label      = m_axis_tdata_o[14:0];
        got.invalid    = m_axis_tdata_o[15];
        got.mean       = m_axis_tdata_o[31:16];
        got.text_empty = m_axis_tdata_o[32];
        got.is_last    = m_axis_tlast_o;
        if (got.kind == KIND_SUMMARY) summaries_seen++;
        else chars_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected result at cycle %0d: %s", cycle_count, describe(got));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: mismatch at cycle %0d: expected %s, got %s",
                       cycle_count, describe(want), describe(got));
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (cycle_count % 128 == 0) sink_mode = $urandom_range(0, 3);
      // long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (sink_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cycle_count % 8 < 5);
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count <= CycleLimit) @(posedge clk_i);
    $display("tb: errors");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    logic [15:0] classes;
    logic [15:0] labels;

    directed_rows = '{
      // after reset: empty sequence, then saturated peak as the only character
      '{ROW_ITEM, 16'd0,     16'd0,  1'b1, 1,  EmptySummary, NoResult},
      '{ROW_ITEM, 16'd100,   16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'hFFFF,  16'd0,  1'b1, 2,  '{KIND_CHAR, 15'd0, 1'b0, 16'd0, 1'b0, 1'b0},
                                               '{KIND_SUMMARY, 15'd0, 1'b0, 16'd32768, 1'b0, 1'b1}},
      // class count zero: every score is a blank step
      '{ROW_CFG,  16'd0,     16'd96, 1'b0, 0,  NoResult, NoResult},
      '{ROW_ITEM, 16'd5000,  16'd0,  1'b0, 0,  NoResult, NoResult},
      '{ROW_ITEM, 16'd7,     16'd0,  1'b1, 1,  EmptySummary, NoResult},
      // three classes, one valid label
      '{ROW_CFG,  16'd3,     16'd1,  1'b0, 0,  NoResult, NoResult},
      '{ROW_ITEM, 16'd10,    16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd20,    16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd20,    16'd0,  1'b0, -1, NoResult, NoResult},
      // repeated winner: suppressed
      '{ROW_ITEM, 16'd0,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd30000, 16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd5,     16'd0,  1'b0, -1, NoResult, NoResult},
      // index 1 is out of the label range
      '{ROW_ITEM, 16'd0,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd0,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd9,     16'd0,  1'b0, 1,  '{KIND_CHAR, 15'd1, 1'b1, 16'd0, 1'b0, 1'b0},
                                               NoResult},
      // blank step resets the repeat check
      '{ROW_ITEM, 16'd3,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd1,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd2,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd0,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd0,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd8,     16'd0,  1'b1, -1, NoResult, NoResult},
      // class count shrinks in the middle of a step
      '{ROW_CFG,  16'd5,     16'd1,  1'b0, 0,  NoResult, NoResult},
      '{ROW_ITEM, 16'd1,     16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd50,    16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_CFG,  16'd2,     16'd1,  1'b0, 0,  NoResult, NoResult},
      '{ROW_ITEM, 16'd40,    16'd0,  1'b0, -1, NoResult, NoResult},
      '{ROW_ITEM, 16'd0,     16'd0,  1'b1, -1, NoResult, NoResult}
    };

    // reset, then release
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        configure(directed_rows[i].a, directed_rows[i].b);
      end else begin
        feed(directed_rows[i].a, directed_rows[i].seq_end, directed_rows[i].n_typed,
             directed_rows[i].r0, directed_rows[i].r1);
      end
    end

    // random phases, each under its own register setting
    phase = 0;
    while (phase < 8 || items_sent < ItemTarget) begin
      case (phase)
        0:       begin classes = 16'd2;     labels = 16'd1;     end
        1:       begin classes = 16'd3;     labels = 16'd32768; end
        2:       begin classes = 16'd3;     labels = 16'd2;     end
        3:       begin classes = 16'hFFFF;  labels = 16'hFFFF;  end
        4:       begin classes = 16'd32768; labels = 16'd1;     end
        5:       begin classes = 16'd1;     labels = 16'd0;     end
        6:       begin classes = 16'd0;     labels = 16'd5;     end
        default: begin
          classes = 16'($urandom_range(2, 10));
          labels  = 16'($urandom_range(0, 10));
        end
      endcase
      wait_idle();
      configure(classes, labels);
      n = classes;
      if (n < 1) n = 1;
      if (n > ClassCapInt) n = ClassCapInt;
      if (phase == 0) hold_req = 1'b1;
      if (phase == 2) begin
        run_long_sequence();
      end else begin
        repeat ($urandom_range(3, 8)) run_sequence(n);
      end
      phase++;
    end

    wait_idle();
    $display("tb: %0d scores in %0d sequences over %0d phases, %0d register writes",
             items_sent, sequences_sent, phase, cfg_writes);
    $display("tb: %0d characters and %0d summaries checked, emit cap %s, %0d mismatches",
             chars_seen, summaries_seen, cap_hit ? "reached" : "not reached", mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cgd_pkg.sv
rtl/cgd_ctrl.sv
rtl/cgd_datapath.sv
rtl/ctc_greedy_decoder_unit.sv
tb/tb.sv
